// ----- hw/rtl/u8cc_pkg.sv -----
// Shared types for the UTF-8 validating character counter.
package u8cc_pkg;

  localparam int unsigned CP_BITS  = 21;
  localparam int unsigned OUT_CNT_BITS = 16;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_string;
  } in_word_t;

  typedef struct packed {
    logic                    char_valid;
    logic [CP_BITS-1:0]      code_point;
    logic                    seq_rejected;
    logic [OUT_CNT_BITS-1:0] running_count;
    logic                    string_done;
  } out_word_t;

  localparam logic [1:0] LEN_NONE  = 2'd0;
  localparam logic [1:0] LEN_TWO   = 2'd1;
  localparam logic [1:0] LEN_THREE = 2'd2;
  localparam logic [1:0] LEN_FOUR  = 2'd3;

endpackage

// ----- hw/rtl/u8cc_stream_if.sv -----
// Valid/ready stream interface carrying one word of a given payload type.
interface u8cc_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/utf8_validating_char_counter.sv -----
// UTF-8 decoder and validator with a saturating per-string character count.
// Result words are registered: output stage, or skid stage while output stalls.
// Throughput: one byte per cycle while the skid stage is empty; a skid stage
// keeps input open for one word while the output is stalled.
// Reset (rst, synchronous): clears decode state and count, empties both output stages.
module utf8_validating_char_counter #(
  parameter int unsigned COUNT_BITS = 16
) (
  input logic clk,
  input logic rst,
  u8cc_stream_if.sink   stream,
  u8cc_stream_if.source chars
);
  import u8cc_pkg::*;

  localparam int unsigned EXT_BITS = (COUNT_BITS > OUT_CNT_BITS) ? COUNT_BITS : OUT_CNT_BITS;

  logic [1:0]            pend, pend_next;
  logic [1:0]            llen, llen_next;
  logic [CP_BITS-1:0]    acc, acc_next;
  logic                  skip, skip_next;
  logic [COUNT_BITS-1:0] count, count_next;

  logic      out_valid, skid_valid;
  out_word_t out_word, skid_word;
  out_word_t res;

  in_word_t           in_w;
  logic               accept;
  logic               is_cont, start, valid, rej;
  logic [CP_BITS-1:0] cp, acc_shift;
  logic [EXT_BITS-1:0] count_ext;

  function automatic logic cp_ok(input logic [1:0] len, input logic [CP_BITS-1:0] v);
    logic ok;
    case (len)
      LEN_NONE:  ok = 1'b0;
      LEN_TWO:   ok = (v > 21'h7F);
      LEN_THREE: ok = (v > 21'h7FF) && (v[15:11] != 5'b11011);
      default:   ok = (v > 21'hFFFF) && (v < 21'h110000);
    endcase
    return ok;
  endfunction

  assign in_w         = stream.payload;
  assign stream.ready = !skid_valid;
  assign accept       = stream.valid && stream.ready;

  assign is_cont   = (in_w.data_byte[7:6] == 2'b10);
  assign acc_shift = {acc[CP_BITS-7:0], in_w.data_byte[5:0]};

  always_comb begin
    pend_next  = pend;
    llen_next  = llen;
    acc_next   = acc;
    skip_next  = skip;
    count_next = count;
    valid      = 1'b0;
    rej        = 1'b0;
    start      = 1'b0;
    cp         = '0;

    if (pend != 2'd0) begin
      if (is_cont) begin
        acc_next  = acc_shift;
        pend_next = pend - 2'd1;
        if (pend == 2'd1) begin
          if (cp_ok(llen, acc_shift)) begin
            valid = 1'b1;
            cp    = acc_shift;
          end else begin
            rej = 1'b1;
          end
        end
      end else begin
        rej       = 1'b1;
        pend_next = 2'd0;
        start     = 1'b1;
      end
    end else if (!(skip && is_cont)) begin
      start = 1'b1;
    end

    if (start) begin
      skip_next = 1'b0;
      if (!in_w.data_byte[7]) begin
        valid = 1'b1;
        cp    = {13'd0, in_w.data_byte};
      end else if (in_w.data_byte[7:5] == 3'b110) begin
        acc_next  = {16'd0, in_w.data_byte[4:0]};
        pend_next = 2'd1;
        llen_next = LEN_TWO;
      end else if (in_w.data_byte[7:4] == 4'b1110) begin
        acc_next  = {17'd0, in_w.data_byte[3:0]};
        pend_next = 2'd2;
        llen_next = LEN_THREE;
      end else if (in_w.data_byte[7:3] == 5'b11110) begin
        acc_next  = {18'd0, in_w.data_byte[2:0]};
        pend_next = 2'd3;
        llen_next = LEN_FOUR;
      end else begin
        rej       = 1'b1;
        skip_next = 1'b1;
      end
    end

    if (valid && (count != {COUNT_BITS{1'b1}})) begin
      count_next = count + COUNT_BITS'(1);
    end

    if (in_w.end_of_string && (pend_next != 2'd0)) begin
      rej = 1'b1;
    end

    count_ext = EXT_BITS'(count_next);

    res.char_valid    = valid;
    res.code_point    = cp;
    res.seq_rejected  = rej;
    res.running_count = (count_ext > EXT_BITS'(17'h0FFFF)) ? {OUT_CNT_BITS{1'b1}}
                                                           : count_ext[OUT_CNT_BITS-1:0];
    res.string_done   = in_w.end_of_string;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend  <= '0;
      llen  <= '0;
      acc   <= '0;
      skip  <= 1'b0;
      count <= '0;
    end else if (accept) begin
      if (in_w.end_of_string) begin
        pend  <= '0;
        llen  <= '0;
        acc   <= '0;
        skip  <= 1'b0;
        count <= '0;
      end else begin
        pend  <= pend_next;
        llen  <= llen_next;
        acc   <= acc_next;
        skip  <= skip_next;
        count <= count_next;
      end
    end
  end

  // output register with one-word skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || chars.ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || chars.ready) begin
      out_word <= skid_valid ? skid_word : res;
    end else if (accept) begin
      skid_word <= res;
    end
  end

  assign chars.valid   = out_valid;
  assign chars.payload = out_word;

endmodule

// ----- sim/utf8_validating_char_counter_tb.sv -----
// Testbench for the UTF-8 validating character counter: directed and random strings, self-checked.
module utf8_validating_char_counter_tb;
  import u8cc_pkg::*;

  localparam int unsigned COUNT_W = 16;
  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned HOLD_CYCLES = 60;
  localparam int unsigned RANDOM_BYTES = 1050;

  class decoded_char_book;
    out_word_t due_q[$];
    int unsigned mismatches;
    int unsigned count_w;
    longint unsigned count_top;
    bit [1:0] conts_left;
    bit [1:0] lead_len;
    bit [20:0] acc;
    bit skipping;
    longint unsigned chars_seen;

    function new(int unsigned w);
      count_w = w;
      count_top = (64'd1 << w) - 1;
      mismatches = 0;
      clear_string();
    endfunction

    function void clear_string();
      conts_left = 0;
      lead_len = 0;
      acc = 0;
      skipping = 0;
      chars_seen = 0;
    endfunction

    function bit legal_value(bit [1:0] len, bit [20:0] v);
      if (len == LEN_TWO) return v > 21'h7F;
      if (len == LEN_THREE) return v > 21'h7FF && (v & 21'hF800) != 21'hD800;
      return v > 21'hFFFF && v < 21'h110000;
    endfunction

    function void take_byte(in_word_t w);
      logic [7:0] b;
      bit cont, good, bad, start;
      bit [20:0] cp;
      out_word_t due;
      b = w.data_byte;
      cont = (b & 8'hC0) == 8'h80;
      good = 0;
      bad = 0;
      start = 0;
      cp = 0;
      if (conts_left != 0) begin
        if (cont) begin
          acc = {acc[14:0], b[5:0]};
          conts_left--;
          if (conts_left == 0) begin
            if (legal_value(lead_len, acc)) begin
              good = 1;
              cp = acc;
            end else begin
              bad = 1;
            end
          end
        end else begin
          // early start byte: drop the pending sequence, decode afresh
          bad = 1;
          conts_left = 0;
          start = 1;
        end
      end else if (!(skipping && cont)) begin
        start = 1;
      end
      if (start) begin
        skipping = 0;
        if (b[7] == 1'b0) begin
          good = 1;
          cp = {13'd0, b};
        end else if (b[7:5] == 3'b110) begin
          acc = {16'd0, b[4:0]};
          conts_left = 1;
          lead_len = LEN_TWO;
        end else if (b[7:4] == 4'b1110) begin
          acc = {17'd0, b[3:0]};
          conts_left = 2;
          lead_len = LEN_THREE;
        end else if (b[7:3] == 5'b11110) begin
          acc = {18'd0, b[2:0]};
          conts_left = 3;
          lead_len = LEN_FOUR;
        end else begin
          bad = 1;
          skipping = 1;
        end
      end
      if (good && chars_seen < count_top) chars_seen++;
      if (w.end_of_string && conts_left != 0) bad = 1;
      due.char_valid = good;
      due.code_point = good ? cp : '0;
      due.seq_rejected = bad;
      due.running_count = (chars_seen > 64'hFFFF) ? 16'hFFFF : chars_seen[15:0];
      due.string_done = w.end_of_string;
      if (w.end_of_string) clear_string();
      due_q.insert(due_q.size(), due);
    endfunction

    function void match_char(out_word_t got);
      out_word_t due;
      if (due_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: valid=%0b cp=%h rej=%0b count=%0d done=%0b",
                   got.char_valid, got.code_point, got.seq_rejected,
                   got.running_count, got.string_done);
        return;
      end
      due = due_q.pop_front();
      if (got.char_valid !== due.char_valid || got.code_point !== due.code_point ||
          got.seq_rejected !== due.seq_rejected ||
          got.running_count !== due.running_count ||
          got.string_done !== due.string_done) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp valid=%0b cp=%h rej=%0b count=%0d done=%0b | %s",
                   due.char_valid, due.code_point, due.seq_rejected,
                   due.running_count, due.string_done,
                   $sformatf("got valid=%0b cp=%h rej=%0b count=%0d done=%0b",
                             got.char_valid, got.code_point, got.seq_rejected,
                             got.running_count, got.string_done));
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  int unsigned send_idle;
  int unsigned recv_idle;
  bit hold_req;
  int unsigned cycle_cnt;
  logic [7:0] text_q[$];
  decoded_char_book book;

  u8cc_stream_if #(.T(in_word_t))  byte_if ();
  u8cc_stream_if #(.T(out_word_t)) char_if ();

  utf8_validating_char_counter #(.COUNT_BITS(COUNT_W)) u_dut (
    .clk   (clk),
    .rst   (rst),
    .stream(byte_if),
    .chars (char_if)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && char_if.valid && char_if.ready) book.match_char(char_if.payload);
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    char_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        char_if.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      char_if.ready = ($urandom_range(0, 99) >= recv_idle);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eos);
    in_word_t w;
    w.data_byte = b;
    w.end_of_string = eos;
    while ($urandom_range(0, 99) < send_idle) begin
      byte_if.valid = 1'b0;
      @(negedge clk);
    end
    byte_if.valid = 1'b1;
    byte_if.payload = w;
    @(posedge clk);
    while (!byte_if.ready) @(posedge clk);
    book.take_byte(w);
    @(negedge clk);
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  function automatic void add_byte(logic [7:0] b);
    text_q.insert(text_q.size(), b);
  endfunction

  function automatic bit [20:0] pick_cp(bit [20:0] lo, bit [20:0] hi);
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r == 0) return lo;
    if (r == 1) return hi;
    return 21'($urandom_range(lo, hi));
  endfunction

  // encodes with the given length whether or not the value is legal for it
  function automatic void put_utf8(bit [20:0] cp, int unsigned n);
    case (n)
      1: add_byte({1'b0, cp[6:0]});
      2: begin
        add_byte({3'b110, cp[10:6]});
        add_byte({2'b10, cp[5:0]});
      end
      3: begin
        add_byte({4'b1110, cp[15:12]});
        add_byte({2'b10, cp[11:6]});
        add_byte({2'b10, cp[5:0]});
      end
      default: begin
        add_byte({5'b11110, cp[20:18]});
        add_byte({2'b10, cp[17:12]});
        add_byte({2'b10, cp[11:6]});
        add_byte({2'b10, cp[5:0]});
      end
    endcase
  endfunction

  function automatic void add_random_char();
    int unsigned r, n, cut;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      put_utf8(pick_cp(21'h0, 21'h7F), 1);
    end else if (r < 35) begin
      put_utf8(pick_cp(21'h80, 21'h7FF), 2);
    end else if (r < 55) begin
      put_utf8(pick_cp(21'h800, 21'hFFFF), 3);
    end else if (r < 70) begin
      put_utf8(pick_cp(21'h10000, 21'h10FFFF), 4);
    end else if (r < 76) begin
      n = $urandom_range(2, 4);
      put_utf8(pick_cp(21'h0, (n == 2) ? 21'h7F : (n == 3) ? 21'h7FF : 21'hFFFF), n);
    end else if (r < 80) begin
      put_utf8(pick_cp(21'h110000, 21'h1FFFFF), 4);
    end else if (r < 84) begin
      put_utf8(pick_cp(21'hD800, 21'hDFFF), 3);
    end else if (r < 90) begin
      n = $urandom_range(2, 4);
      put_utf8(21'($urandom_range(0, 21'h1FFFFF)), n);
      cut = $urandom_range(1, n - 1);
      repeat (cut) text_q.delete(text_q.size() - 1);
    end else begin
      add_byte(8'($urandom_range(0, 255)));
    end
  endfunction

  initial begin
    int unsigned random_sent, nchars;
    bit held;
    rst = 1'b1;
    byte_if.valid = 1'b0;
    byte_if.payload = '0;
    send_idle = 25;
    recv_idle = 58;
    hold_req = 1'b0;
    cycle_cnt = 0;
    random_sent = 0;
    held = 0;
    book = new(COUNT_W);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // ASCII ends, two- and three-byte limits, overlong, surrogate
    text_q = '{8'h00, 8'h7F, 8'hC2, 8'h80, 8'hC0, 8'h80, 8'hE0, 8'hA0, 8'h80,
               8'hED, 8'hA0, 8'h80};
    send_text();
    // four-byte max and beyond, bad lead with a skipped tail, early start byte
    text_q = '{8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'hF4, 8'h90, 8'h80, 8'h80, 8'hFF, 8'h80,
               8'hC2, 8'h41};
    send_text();
    // truncated at end of string
    text_q = '{8'hE2, 8'h82};
    send_text();

    while (random_sent < RANDOM_BYTES) begin
      if (random_sent < RANDOM_BYTES / 3) begin
        send_idle = 25;
        recv_idle = 58;
      end else if (random_sent < 2 * RANDOM_BYTES / 3) begin
        send_idle = 58;
        recv_idle = 25;
      end else begin
        send_idle = 0;
        recv_idle = 0;
        if (!held) begin
          hold_req = 1'b1;
          held = 1;
        end
      end
      nchars = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 90) : $urandom_range(1, 12);
      repeat (nchars) add_random_char();
      random_sent += text_q.size();
      send_text();
    end
    byte_if.valid = 1'b0;

    while (book.due_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (book.mismatches == 0 && book.due_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- utf8_validating_char_counter.f -----
hw/rtl/u8cc_pkg.sv
hw/rtl/u8cc_stream_if.sv
hw/rtl/utf8_validating_char_counter.sv
sim/utf8_validating_char_counter_tb.sv
